@@ src/hhlp_pkg.sv @@
// ----------------------------------------------------------------------------
// hhlp_pkg
// Shared types and constants for the HTTP header line parser: parser state
// codes, event codes, character codes and default widths.
// ----------------------------------------------------------------------------
package hhlp_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int FIELD_W      = 16;
  localparam int COUNT_W      = 8;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  typedef enum logic [3:0] {
    ST_START       = 4'd0,
    ST_KEY_START   = 4'd1,
    ST_KEY         = 4'd2,
    ST_COLON       = 4'd3,
    ST_SPACE       = 4'd4,
    ST_VALUE_START = 4'd5,
    ST_VALUE       = 4'd6,
    ST_LINE_CR     = 4'd7,
    ST_END_CR      = 4'd8,
    ST_FINISHED    = 4'd9,
    ST_FAILED      = 4'd10
  } hhlp_state_t;

  typedef enum logic [1:0] {
    EV_LINE  = 2'd0,
    EV_END   = 2'd1,
    EV_ERROR = 2'd2
  } hhlp_event_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [ADDR_W-3:0] REG_BASE_OFFSET = '0;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic [FIELD_W-1:0] sat_inc16(input logic [FIELD_W-1:0] v);
    return (v == {FIELD_W{1'b1}}) ? v : v + FIELD_W'(1);
  endfunction

endpackage

@@ src/http_header_line_parser.sv @@
// ----------------------------------------------------------------------------
// http_header_line_parser
// Byte-serial parser for an HTTP header block: reports each completed
// "Key: value" line, the end of the block and the first syntax error.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one header byte per transaction, with
//   in_last_byte marking the final byte of the block. After that byte the
//   parser returns to its start state and the position restarts at base_offset.
//   Result channel (out_valid/out_ready): at most one result per byte: a
//   completed line (key/value offsets and lengths), end of headers, or a
//   syntax error. After end or error, bytes are dropped until the last byte.
//   Config (APB, paddr 0): base_offset, the position of the first byte.
// Latency: a result appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_ready is high; a held result that is
//   not taken stalls the input.
// Reset: synchronous, active low; state, counters and base_offset clear.
// Stall: a held result keeps out_* stable; in_ready stays high as long as the
//   result register is empty or is taken in the same cycle.
// ----------------------------------------------------------------------------
module http_header_line_parser #(
  parameter int POSITION_BITS = hhlp_pkg::POS_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_last_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_event_kind,
  output logic [hhlp_pkg::FIELD_W-1:0] out_key_offset,
  output logic [hhlp_pkg::FIELD_W-1:0] out_key_length,
  output logic [hhlp_pkg::FIELD_W-1:0] out_value_offset,
  output logic [hhlp_pkg::FIELD_W-1:0] out_value_length,
  output logic [hhlp_pkg::COUNT_W-1:0] out_header_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hhlp_pkg::ADDR_W-1:0]  paddr,
  input  logic [hhlp_pkg::DATA_W-1:0]  pwdata,
  output logic [hhlp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import hhlp_pkg::*;

  localparam int P = POSITION_BITS;

  hhlp_state_t        state_r, state_nxt;
  logic [P-1:0]       bpos_r, bpos_nxt;
  logic [P-1:0]       kstart_r, kstart_nxt;
  logic [P-1:0]       vstart_r, vstart_nxt;
  logic [FIELD_W-1:0] klen_r, klen_nxt;
  logic [FIELD_W-1:0] vlen_r, vlen_nxt;
  logic [COUNT_W-1:0] lines_r, lines_nxt;
  logic [FIELD_W-1:0] base_r;

  logic               ov_r;
  hhlp_event_t        ev_r, ev_nxt;
  logic [FIELD_W-1:0] ko_r, ko_nxt, kl_r, kl_nxt, vo_r, vo_nxt, vl_r, vl_nxt;
  logic [COUNT_W-1:0] hc_r, hc_nxt;

  logic               accept, emit, reg_sel, cfg_wr;
  logic [P-1:0]       pos;
  logic [7:0]         c;

  assign accept  = in_valid && in_ready;
  assign in_ready = !ov_r || out_ready;
  assign c       = in_data_byte;
  assign pos     = P'(32'(base_r) + 32'(bpos_r));

  assign reg_sel = (paddr[ADDR_W-1:2] == REG_BASE_OFFSET);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? DATA_W'(base_r) : '0;

  // Next parser state
  always_comb begin
    state_nxt = ST_FAILED;
    unique case (state_r)
      ST_START: begin
        if (c == CH_SPACE || c == CH_COLON) state_nxt = ST_START;
        else if (c == CH_CR) state_nxt = ST_END_CR;
        else if (c == CH_LF) state_nxt = ST_FINISHED;
        else if (is_letter(c)) state_nxt = ST_KEY_START;
      end
      ST_KEY_START, ST_KEY: begin
        if (c == CH_COLON) state_nxt = ST_COLON;
        else if (is_letter(c) || c == CH_DASH) state_nxt = ST_KEY;
      end
      ST_COLON: begin
        if (c == CH_SPACE) state_nxt = ST_SPACE;
      end
      ST_SPACE: begin
        if (c == CH_SPACE) state_nxt = ST_SPACE;
        else if (c != CH_CR && c != CH_LF) state_nxt = ST_VALUE_START;
      end
      ST_VALUE_START, ST_VALUE, ST_LINE_CR: begin
        if (c == CH_CR) state_nxt = ST_LINE_CR;
        else if (c == CH_LF) state_nxt = ST_START;
        else if (state_r != ST_LINE_CR) state_nxt = ST_VALUE;
      end
      ST_END_CR: begin
        if (c == CH_CR) state_nxt = ST_END_CR;
        else if (c == CH_LF) state_nxt = ST_FINISHED;
      end
      ST_FINISHED: state_nxt = ST_FINISHED;
      default:     state_nxt = ST_FAILED;
    endcase
  end

  // Datapath and result
  always_comb begin
    logic line_done;
    line_done  = 1'b0;
    kstart_nxt = kstart_r;
    klen_nxt   = klen_r;
    vstart_nxt = vstart_r;
    vlen_nxt   = vlen_r;
    lines_nxt  = lines_r;
    bpos_nxt   = bpos_r + P'(1);
    emit       = 1'b0;
    ev_nxt     = EV_LINE;
    ko_nxt     = '0;
    kl_nxt     = '0;
    vo_nxt     = '0;
    vl_nxt     = '0;

    case (state_r)
      ST_START: begin
        if (state_nxt == ST_KEY_START) begin
          kstart_nxt = pos;
          klen_nxt   = FIELD_W'(1);
        end
      end
      ST_KEY_START, ST_KEY: begin
        if (state_nxt == ST_KEY) klen_nxt = sat_inc16(klen_r);
      end
      ST_SPACE: begin
        if (state_nxt == ST_VALUE_START) begin
          vstart_nxt = pos;
          vlen_nxt   = FIELD_W'(1);
        end
      end
      ST_VALUE_START, ST_VALUE, ST_LINE_CR: begin
        if (state_nxt == ST_VALUE) vlen_nxt = sat_inc16(vlen_r);
        else if (state_nxt == ST_START) line_done = 1'b1;
      end
      default: ;
    endcase

    if (line_done) begin
      if (lines_r != {COUNT_W{1'b1}}) lines_nxt = lines_r + COUNT_W'(1);
      emit       = 1'b1;
      ev_nxt     = EV_LINE;
      ko_nxt     = FIELD_W'(kstart_r);
      kl_nxt     = klen_r;
      vo_nxt     = FIELD_W'(32'(vstart_r));
      vl_nxt     = vlen_r;
      kstart_nxt = '0;
      klen_nxt   = '0;
      vstart_nxt = '0;
      vlen_nxt   = '0;
    end

    if (state_r <= ST_END_CR) begin
      if (state_nxt == ST_FINISHED) begin
        emit   = 1'b1;
        ev_nxt = EV_END;
      end else if (state_nxt == ST_FAILED) begin
        emit   = 1'b1;
        ev_nxt = EV_ERROR;
      end
    end
    hc_nxt = lines_nxt;

    if (in_last_byte) begin
      bpos_nxt   = '0;
      kstart_nxt = '0;
      klen_nxt   = '0;
      vstart_nxt = '0;
      vlen_nxt   = '0;
      lines_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_START;
      bpos_r   <= '0;
      kstart_r <= '0;
      klen_r   <= '0;
      vstart_r <= '0;
      vlen_r   <= '0;
      lines_r  <= '0;
      base_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_wr && reg_sel) base_r <= pwdata[FIELD_W-1:0];
      if (accept) begin
        state_r  <= in_last_byte ? ST_START : state_nxt;
        bpos_r   <= bpos_nxt;
        kstart_r <= kstart_nxt;
        klen_r   <= klen_nxt;
        vstart_r <= vstart_nxt;
        vlen_r   <= vlen_nxt;
        lines_r  <= lines_nxt;
        ov_r     <= emit;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      ev_r <= ev_nxt;
      ko_r <= ko_nxt;
      kl_r <= kl_nxt;
      vo_r <= vo_nxt;
      vl_r <= vl_nxt;
      hc_r <= hc_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_event_kind   = ev_r;
  assign out_key_offset   = ko_r;
  assign out_key_length   = kl_r;
  assign out_value_offset = vo_r;
  assign out_value_length = vl_r;
  assign out_header_count = hc_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> ov_r)
    else $error("input stalled with empty result register");

  a_line_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ev_r == EV_LINE) |-> (kl_r != '0 && vl_r != '0 && hc_r != '0))
    else $error("line result with empty key, value or count");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> (state_r == ST_START && bpos_r == '0 && lines_r == '0))
    else $error("parser not restarted after last byte");

  a_no_result_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (state_r == ST_FINISHED || state_r == ST_FAILED)) |=> !ov_r)
    else $error("result produced after end or error");

endmodule
